[design/rmez_pkg.sv]
// ----------------------------------------------------------------------------
// rmez_pkg
// types and constants for the rotation matrix to zyx euler angle unit
// ----------------------------------------------------------------------------
package rmez_pkg;

    localparam int CordicSteps = 16;
    localparam int CordicW     = 28;
    localparam int AngW        = 20;
    localparam int SqW         = 32;
    localparam int RootW       = 17;

    localparam logic signed [AngW-1:0] PiQ16    = 20'sd205887;
    localparam logic signed [15:0]     AngLimit = 16'sd25736;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
    } req_t;

    typedef struct packed {
        logic signed [15:0] yaw_z;
        logic signed [15:0] pitch_y;
        logic signed [15:0] roll_x;
        logic               singular;
    } rsp_t;

    typedef struct packed {
        logic signed [CordicW-1:0] x;
        logic signed [CordicW-1:0] y;
        logic signed [AngW-1:0]    z;
        logic                      zero;
    } cord_t;

    function automatic logic signed [AngW-1:0] atan_tab(input int i);
        case (i)
            0:  atan_tab = 20'sd51472;
            1:  atan_tab = 20'sd30386;
            2:  atan_tab = 20'sd16055;
            3:  atan_tab = 20'sd8150;
            4:  atan_tab = 20'sd4091;
            5:  atan_tab = 20'sd2047;
            6:  atan_tab = 20'sd1024;
            7:  atan_tab = 20'sd512;
            8:  atan_tab = 20'sd256;
            9:  atan_tab = 20'sd128;
            10: atan_tab = 20'sd64;
            11: atan_tab = 20'sd32;
            12: atan_tab = 20'sd16;
            13: atan_tab = 20'sd8;
            14: atan_tab = 20'sd4;
            15: atan_tab = 20'sd2;
            default: atan_tab = '0;
        endcase
    endfunction

    // prescale and quadrant fold of one atan2 operand pair
    function automatic cord_t cord_init(input logic signed [17:0] y,
                                        input logic signed [17:0] x);
        cord_t c;
        logic signed [CordicW-1:0] xs;
        logic signed [CordicW-1:0] ys;
        xs = {{(CordicW-26){x[17]}}, x, 8'd0};
        ys = {{(CordicW-26){y[17]}}, y, 8'd0};
        c.zero = (x == 18'sd0) && (y == 18'sd0);
        if (xs < 0)
        begin
            c.x = -xs;
            c.y = -ys;
            c.z = (ys >= 0) ? PiQ16 : -PiQ16;
        end
        else
        begin
            c.x = xs;
            c.y = ys;
            c.z = '0;
        end
        return c;
    endfunction

    function automatic cord_t cord_step(input cord_t c, input int i);
        cord_t o;
        o = c;
        if (c.y >= 0)
        begin
            o.x = c.x + (c.y >>> i);
            o.y = c.y - (c.x >>> i);
            o.z = c.z + atan_tab(i);
        end
        else
        begin
            o.x = c.x - (c.y >>> i);
            o.y = c.y + (c.x >>> i);
            o.z = c.z - atan_tab(i);
        end
        return o;
    endfunction

    function automatic logic signed [15:0] cord_final(input cord_t c);
        logic signed [AngW-1:0] r;
        r = (c.z + 20'sd4) >>> 3;
        if (c.zero)
            return '0;
        if (r > AngW'(AngLimit))
            return AngLimit;
        if (r < -AngW'(AngLimit))
            return -AngLimit;
        return r[15:0];
    endfunction

endpackage

[design/rmez_front.sv]
// ----------------------------------------------------------------------------
// rmez_front
// magnitude of (r21, r22) by a pipelined bit-pair square root, then branch
// classification against the singular limit
// ----------------------------------------------------------------------------
module rmez_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  rmez_pkg::req_t       in_req,
    input  logic [14:0]          limit,
    input  logic                 stall,
    output logic                 out_valid,
    output rmez_pkg::req_t       out_req,
    output logic [16:0]          out_cy,
    output logic                 out_sing
);
    import rmez_pkg::*;

    localparam int Stages = SqW / 2;

    logic [Stages:0]           vld_reg;
    req_t                      req_reg  [Stages+1];
    logic [SqW-1:0]            rem_reg  [Stages+1];
    logic [RootW-1:0]          root_reg [Stages+1];
    logic [SqW-1:0]            sq_next;
    logic signed [31:0]        p21;
    logic signed [31:0]        p22;

    assign p21 = in_req.r21 * in_req.r21;
    assign p22 = in_req.r22 * in_req.r22;
    assign sq_next = 32'(p21) + 32'(p22);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (!stall)
            vld_reg <= {vld_reg[Stages-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            req_reg[0]  <= in_req;
            rem_reg[0]  <= sq_next;
            root_reg[0] <= '0;
        end
    end

    // restoring square root, one result bit per stage
    for (genvar s = 0; s < Stages; s++)
    begin : g_sqrt
        logic [SqW+1:0] trial;
        logic [SqW+1:0] rem_w;
        logic [SqW+1:0] rt_w;
        assign rem_w = {2'b00, rem_reg[s]} >> (2 * (Stages - 1 - s));
        assign rt_w  = {{(SqW-RootW){1'b0}}, root_reg[s], 2'b01};
        assign trial = rt_w[SqW+1:0];
        always_ff @(posedge clk)
        begin
            if (!stall)
            begin
                req_reg[s+1] <= req_reg[s];
                if (rem_w >= trial)
                begin
                    rem_reg[s+1]  <= rem_reg[s] - SqW'(trial << (2 * (Stages - 1 - s)));
                    root_reg[s+1] <= {root_reg[s][RootW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1]  <= rem_reg[s];
                    root_reg[s+1] <= {root_reg[s][RootW-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[Stages];
    assign out_req   = req_reg[Stages];
    assign out_cy    = root_reg[Stages];
    assign out_sing  = root_reg[Stages] < {2'b00, limit};

endmodule

[design/rmez_queue.sv]
// ----------------------------------------------------------------------------
// rmez_queue
// small fifo between classification and the cordic back end
// ----------------------------------------------------------------------------
module rmez_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         not_empty,
    output logic         almost_full
);
    localparam int Depth = 4;

    logic [W-1:0] mem_reg [Depth];
    logic [1:0]   wp_reg;
    logic [1:0]   rp_reg;
    logic [2:0]   cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 2'd1;
            if (pop)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b00, push} - {2'b00, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

    assign rdata       = mem_reg[rp_reg];
    assign not_empty   = cnt_reg != 3'd0;
    assign almost_full = cnt_reg >= 3'd3;

endmodule

[design/rmez_back.sv]
// ----------------------------------------------------------------------------
// rmez_back
// three unrolled vectoring cordic pipelines for roll, pitch and yaw
// ----------------------------------------------------------------------------
module rmez_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  rmez_pkg::req_t   in_req,
    input  logic [16:0]      in_cy,
    input  logic             in_sing,
    output logic             out_valid,
    output rmez_pkg::rsp_t   out_rsp
);
    import rmez_pkg::*;

    logic [CordicSteps:0] vld_reg;
    logic                 sing_reg [CordicSteps+1];
    cord_t                roll_reg [CordicSteps+1];
    cord_t                pit_reg  [CordicSteps+1];
    cord_t                yaw_reg  [CordicSteps+1];
    rsp_t                 rsp_reg;
    logic                 ovld_reg;
    logic signed [17:0]   ry;
    logic signed [17:0]   rx;

    assign ry = in_sing ? -18'(in_req.r12) : 18'(in_req.r21);
    assign rx = in_sing ?  18'(in_req.r11) : 18'(in_req.r22);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[CordicSteps-1:0], in_valid};
            ovld_reg <= vld_reg[CordicSteps];
        end
    end

    always_ff @(posedge clk)
    begin
        sing_reg[0] <= in_sing;
        roll_reg[0] <= cord_init(ry, rx);
        pit_reg[0]  <= cord_init(-18'(in_req.r20), {1'b0, in_cy});
        yaw_reg[0]  <= cord_init(18'(in_req.r10), 18'(in_req.r00));
    end

    for (genvar i = 0; i < CordicSteps; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            sing_reg[i+1] <= sing_reg[i];
            roll_reg[i+1] <= cord_step(roll_reg[i], i);
            pit_reg[i+1]  <= cord_step(pit_reg[i], i);
            yaw_reg[i+1]  <= cord_step(yaw_reg[i], i);
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg.roll_x   <= cord_final(roll_reg[CordicSteps]);
        rsp_reg.pitch_y  <= cord_final(pit_reg[CordicSteps]);
        rsp_reg.yaw_z    <= sing_reg[CordicSteps] ? '0 : cord_final(yaw_reg[CordicSteps]);
        rsp_reg.singular <= sing_reg[CordicSteps];
    end

    assign out_valid = ovld_reg;
    assign out_rsp   = rsp_reg;

endmodule

[design/rotation_matrix_to_euler_zyx_unit.sv]
// throughput: one request per cycle; busy never rises since the back end never stalls
// latency is set by the 16-stage square root, the queue slot, the 16-stage cordic
// pipelines and the input and output registers around them
// reset: rst_n clears all valid bits and sets limit_reg to 1
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_zyx_unit
// converts rotation matrix entries to zyx euler angles
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_zyx_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rmez_pkg::req_t req,
    output logic           done,
    output rmez_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [14:0]    cfg_data
);
    import rmez_pkg::*;

    localparam int QW = $bits(req_t) + RootW + 1;

    logic [14:0]   limit_reg;
    logic          f_valid;
    req_t          f_req;
    logic [16:0]   f_cy;
    logic          f_sing;
    logic [QW-1:0] q_rdata;
    logic          q_ne;
    logic          q_af;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= 15'd1;
        else if (cfg_valid && cfg_ready)
            limit_reg <= cfg_data;
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    rmez_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_req    (req),
        .limit     (limit_reg),
        .stall     (1'b0),
        .out_valid (f_valid),
        .out_req   (f_req),
        .out_cy    (f_cy),
        .out_sing  (f_sing)
    );

    rmez_queue #(.W(QW)) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (f_valid),
        .wdata       ({f_req, f_cy, f_sing}),
        .pop         (q_ne),
        .rdata       (q_rdata),
        .not_empty   (q_ne),
        .almost_full (q_af)
    );

    rmez_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_ne && !q_af || q_ne),
        .in_req    (q_rdata[QW-1 -: $bits(req_t)]),
        .in_cy     (q_rdata[RootW:1]),
        .in_sing   (q_rdata[0]),
        .out_valid (done),
        .out_rsp   (rsp)
    );

endmodule
